// File: rtl/core/ehq_pkg.sv
// Shared types, widths and codes of the event min-heap queue.
package ehq_pkg;

    localparam int DEF_CAPACITY = 1024;

    localparam int KEY_W     = 32;
    localparam int KIND_W    = 8;
    localparam int ID_W      = 16;
    localparam int COUNT_W   = 11;
    localparam int STATUS_W  = 2;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 104;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   subject;
        logic [ID_W-1:0]   object;
        logic [ID_W-1:0]   round;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        entry_t              ev;
        logic [COUNT_W-1:0]  count;
        logic                empty;
    } result_t;

endpackage

// File: rtl/core/ehq_mem.sv
// Heap entry store: one write port, one registered read port.
module ehq_mem
    import ehq_pkg::*;
#(
    parameter int DEPTH = DEF_CAPACITY,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/ehq_ctrl.sv
// Heap sequencer: insert with sift-up, pop with sift-down, over the entry store.
module ehq_ctrl
    import ehq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          in_req,
    input  entry_t        in_ev,
    output logic          res_valid,
    input  logic          res_ready,
    output result_t       res,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output entry_t        wr_data,
    output logic [AW-1:0] rd_addr,
    input  entry_t        rd_data
);

    localparam int IW = CW + 1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UP_STEP  = 4'd1;
    localparam logic [3:0] S_UP_CMP   = 4'd2;
    localparam logic [3:0] S_POP_ROOT = 4'd3;
    localparam logic [3:0] S_POP_LAST = 4'd4;
    localparam logic [3:0] S_DN_STEP  = 4'd5;
    localparam logic [3:0] S_DN_L     = 4'd6;
    localparam logic [3:0] S_DN_R     = 4'd7;
    localparam logic [3:0] S_FIN      = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       pos_reg, pos_next;
    entry_t              elem_reg, elem_next;
    entry_t              cand_reg, cand_next;
    logic                cand_child_reg, cand_child_next;
    entry_t              out_ev_reg, out_ev_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [AW-1:0] parent_w;
    logic [IW-1:0] left_w, right_w, count_w;

    assign parent_w = (pos_reg - AW'(1)) >> 1;
    assign left_w   = (IW'(pos_reg) << 1) | IW'(1);
    assign right_w  = left_w + IW'(1);
    assign count_w  = IW'(count_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        elem_next       = elem_reg;
        cand_next       = cand_reg;
        cand_child_next = cand_child_reg;
        out_ev_next     = out_ev_reg;
        status_next     = status_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = elem_reg;
        rd_addr         = '0;
        in_ready        = (state_reg == S_IDLE);
        res_valid       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    elem_next   = in_ev;
                    out_ev_next = '0;
                    status_next = ST_OK;
                    if (in_req == REQ_INSERT)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            pos_next   = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                            state_next = S_UP_STEP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            // root read goes out on the default address
                            count_next = count_reg - CW'(1);
                            state_next = S_POP_ROOT;
                        end
                    end
                end
            end
            S_UP_STEP:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    rd_addr    = parent_w;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (elem_reg.key < rd_data.key)
                begin
                    wr_data    = rd_data;
                    pos_next   = parent_w;
                    state_next = S_UP_STEP;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_POP_ROOT:
            begin
                out_ev_next = rd_data;
                if (count_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    rd_addr    = count_reg[AW-1:0];
                    state_next = S_POP_LAST;
                end
            end
            S_POP_LAST:
            begin
                elem_next  = rd_data;
                pos_next   = '0;
                state_next = S_DN_STEP;
            end
            S_DN_STEP:
            begin
                if (left_w >= count_w)
                begin
                    wr_en      = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    rd_addr    = left_w[AW-1:0];
                    state_next = S_DN_L;
                end
            end
            S_DN_L:
            begin
                if (rd_data.key < elem_reg.key)
                begin
                    cand_next       = rd_data;
                    cand_child_next = 1'b1;
                end
                else
                begin
                    cand_next       = elem_reg;
                    cand_child_next = 1'b0;
                end
                rd_addr    = right_w[AW-1:0];
                state_next = S_DN_R;
            end
            S_DN_R:
            begin
                wr_en = 1'b1;
                if ((right_w < count_w) && (rd_data.key < cand_reg.key))
                begin
                    wr_data    = rd_data;
                    pos_next   = right_w[AW-1:0];
                    state_next = S_DN_STEP;
                end
                else if (cand_child_reg)
                begin
                    wr_data    = cand_reg;
                    pos_next   = left_w[AW-1:0];
                    state_next = S_DN_STEP;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status = status_reg;
        res.ev     = out_ev_reg;
        res.count  = COUNT_W'(count_reg);
        res.empty  = (count_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        elem_reg       <= elem_next;
        cand_reg       <= cand_next;
        cand_child_reg <= cand_child_next;
        out_ev_reg     <= out_ev_next;
        status_reg     <= status_next;
    end

endmodule

// File: rtl/core/event_min_heap_queue_top.sv
// Top level of the event min-heap queue: stream ports, result register, heap core.
//
// A binary min-heap of timed events keyed on a 32-bit unsigned time. Each input
// word is an insert or a pop, and each gives exactly one result word. An insert
// goes to the first free slot and sifts up while strictly earlier than its
// parent; a pop returns the root, moves the last entry to the root and sifts it
// down, preferring the left child on ties. Insert into a full heap is dropped
// with status 1; pop on an empty heap returns status 2; the event fields
// are zero unless a pop succeeds. Entries live in one single-port-write,
// registered-read memory and the moving entry is held in a register, so one
// memory access per cycle sets the pace. One word is in flight at a time.
// The next word can be taken no earlier than the cycle after the result
// register is loaded. The result is held in an output register, so the next
// word is accepted while an earlier result waits on m_tready. No clearing
// pass is needed after reset.
module event_min_heap_queue_top
    import ehq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // event_time[31:0], event_kind[39:32], subject_id[55:40], object_id[71:56],
    // round_number[87:72]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // req_type[0]
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_time[31:0], out_kind[39:32], out_subject[55:40], out_object[71:56],
    // out_round[87:72], entry_count[98:88], is_empty[99], zero[103:100]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]   m_tuser
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    entry_t        in_ev;
    result_t       res;
    logic          res_valid, res_ready;
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    entry_t        wr_data, rd_data;

    logic    m_tvalid_reg, m_tvalid_next;
    result_t m_res_reg;

    // unpack the input word into an entry
    assign in_ev.key     = s_tdata[31:0];
    assign in_ev.kind    = s_tdata[39:32];
    assign in_ev.subject = s_tdata[55:40];
    assign in_ev.object  = s_tdata[71:56];
    assign in_ev.round   = s_tdata[87:72];

    ehq_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_tuser[0]),
        .in_ev     (in_ev),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    ehq_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // load the result register whenever it is empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (res_ready)
        begin
            m_tvalid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_res_reg <= res;
        end
    end

    // pack the result word
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {4'b0000,
                       m_res_reg.empty,
                       m_res_reg.count,
                       m_res_reg.ev.round,
                       m_res_reg.ev.object,
                       m_res_reg.ev.subject,
                       m_res_reg.ev.kind,
                       m_res_reg.ev.key};

endmodule

// File: tb/heap_result_checker.sv
// Result checker for the event min-heap queue: predicts every result word and compares it.
module heap_result_checker
    import ehq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // event_time[31:0], event_kind[39:32], subject_id[55:40], object_id[71:56],
    // round_number[87:72]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // req_type[0]
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // out_time[31:0], out_kind[39:32], out_subject[55:40], out_object[71:56],
    // out_round[87:72], entry_count[98:88], is_empty[99], zero[103:100]
    input  logic [OUT_DATA_W-1:0] m_tdata,
    // status[1:0]
    input  logic [STATUS_W-1:0]   m_tuser,
    output int                    fail_count,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    entry_t      heap_slots [CAPACITY];
    int unsigned heap_fill = 0;
    result_t     due_results [$];
    int          fails = 0;
    int          due = 0;

    result_t     want;
    result_t     got;
    entry_t      req_ev;

    assign fail_count  = fails;
    assign outstanding = due;

    task automatic report_mismatch(input string field, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, field, got_v, want_v);
        fails++;
    endtask

    function automatic void swap_slots(input int unsigned a, input int unsigned b);
        entry_t tmp;
        tmp           = heap_slots[a];
        heap_slots[a] = heap_slots[b];
        heap_slots[b] = tmp;
    endfunction

    // Apply one request to the predicted heap and return the result word it gives.
    function automatic result_t heap_apply(input logic req, input entry_t ev);
        result_t     r;
        int unsigned pos;
        int unsigned parent;
        int unsigned left;
        int unsigned right;
        int unsigned best;
        bit          walking;
        r = '0;
        if (req == REQ_INSERT)
        begin
            if (heap_fill >= CAPACITY)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                pos             = heap_fill;
                heap_slots[pos] = ev;
                heap_fill++;
                walking = 1'b1;
                while (walking && pos > 0)
                begin
                    parent = (pos - 1) / 2;
                    if (heap_slots[pos].key < heap_slots[parent].key)
                    begin
                        swap_slots(pos, parent);
                        pos = parent;
                    end
                    else
                    begin
                        walking = 1'b0;
                    end
                end
            end
        end
        else
        begin
            if (heap_fill == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.ev = heap_slots[0];
                heap_fill--;
                heap_slots[0] = heap_slots[heap_fill];
                pos     = 0;
                walking = 1'b1;
                while (walking)
                begin
                    left  = pos * 2 + 1;
                    right = pos * 2 + 2;
                    best  = pos;
                    if (left < heap_fill && heap_slots[left].key < heap_slots[best].key)
                        best = left;
                    if (right < heap_fill && heap_slots[right].key < heap_slots[best].key)
                        best = right;
                    if (best == pos)
                    begin
                        walking = 1'b0;
                    end
                    else
                    begin
                        swap_slots(pos, best);
                        pos = best;
                    end
                end
            end
        end
        r.count = heap_fill[COUNT_W-1:0];
        r.empty = (heap_fill == 0);
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Check the result first: it can never belong to a word taken at this edge.
            if (m_tvalid && m_tready)
            begin
                got.status     = m_tuser;
                got.ev.key     = m_tdata[31:0];
                got.ev.kind    = m_tdata[39:32];
                got.ev.subject = m_tdata[55:40];
                got.ev.object  = m_tdata[71:56];
                got.ev.round   = m_tdata[87:72];
                got.count      = m_tdata[98:88];
                got.empty      = m_tdata[99];
                if (due_results.size() == 0)
                begin
                    report_mismatch("result with none due", m_tdata[31:0], 32'd0);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.ev.key !== want.ev.key)
                        report_mismatch("out_time", got.ev.key, want.ev.key);
                    if (got.ev.kind !== want.ev.kind)
                        report_mismatch("out_kind", 32'(got.ev.kind), 32'(want.ev.kind));
                    if (got.ev.subject !== want.ev.subject)
                        report_mismatch("out_subject", 32'(got.ev.subject),
                                        32'(want.ev.subject));
                    if (got.ev.object !== want.ev.object)
                        report_mismatch("out_object", 32'(got.ev.object),
                                        32'(want.ev.object));
                    if (got.ev.round !== want.ev.round)
                        report_mismatch("out_round", 32'(got.ev.round), 32'(want.ev.round));
                    if (got.count !== want.count)
                        report_mismatch("entry_count", 32'(got.count), 32'(want.count));
                    if (got.empty !== want.empty)
                        report_mismatch("is_empty", 32'(got.empty), 32'(want.empty));
                    if (m_tdata[103:100] !== 4'd0)
                        report_mismatch("padding", 32'(m_tdata[103:100]), 32'd0);
                end
            end
            if (s_tvalid && s_tready)
            begin
                req_ev.key     = s_tdata[31:0];
                req_ev.kind    = s_tdata[39:32];
                req_ev.subject = s_tdata[55:40];
                req_ev.object  = s_tdata[71:56];
                req_ev.round   = s_tdata[87:72];
                due_results.push_back(heap_apply(s_tuser[0], req_ev));
            end
            due = due_results.size();
        end
    end

endmodule

// File: tb/tb_event_min_heap_queue_top.sv
// Testbench top of the event min-heap queue: clock, reset, stimulus and verdict.
module tb_event_min_heap_queue_top
    import ehq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = DEF_CAPACITY;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // event_time[31:0], event_kind[39:32], subject_id[55:40], object_id[71:56],
    // round_number[87:72]
    logic [IN_DATA_W-1:0]  s_tdata;
    // req_type[0]
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // out_time[31:0], out_kind[39:32], out_subject[55:40], out_object[71:56],
    // out_round[87:72], entry_count[98:88], is_empty[99], zero[103:100]
    logic [OUT_DATA_W-1:0] m_tdata;
    // status[1:0]
    logic [STATUS_W-1:0]   m_tuser;

    int                    fail_count;
    int                    outstanding;

    // Handshakes seen at the last rising edge, read back at the falling edge.
    logic                  s_took;
    logic                  m_took;

    // Set while both sides must run without idling.
    bit                    steady;
    // Mirrors whether s_tvalid is currently being driven high.
    bit                    s_driving;
    // Occupancy as the stimulus sees it: one result per word, so it stays exact.
    int unsigned           fill_level;

    event_min_heap_queue_top #(.CAPACITY(CAP)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    heap_result_checker #(.CAPACITY(CAP)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        s_took <= s_tvalid && s_tready;
        m_took <= m_tvalid && m_tready;
    end

    // Idle length for one word on either side; none during steady stretches.
    function automatic int unsigned draw_pause();
        return steady ? 0 : $urandom_range(0, 6);
    endfunction

    // Bias the keys towards the extremes and towards a narrow band, so that
    // equal times meet often and the tie rule gets exercised in both sift directions.
    function automatic entry_t random_event();
        entry_t ev;
        case ($urandom_range(0, 9))
            0:       ev.key = 32'd0;
            1:       ev.key = 32'hFFFF_FFFF;
            2, 3, 4: ev.key = $urandom_range(0, 15);
            default: ev.key = $urandom;
        endcase
        ev.kind    = 8'($urandom_range(0, 255));
        ev.subject = 16'($urandom_range(0, 65535));
        ev.object  = 16'($urandom_range(0, 65535));
        ev.round   = 16'($urandom_range(0, 65535));
        return ev;
    endfunction

    function automatic entry_t make_event(input logic [31:0] key, input logic [7:0] kind,
                                          input logic [15:0] subject,
                                          input logic [15:0] object,
                                          input logic [15:0] round);
        entry_t ev;
        ev.key     = key;
        ev.kind    = kind;
        ev.subject = subject;
        ev.object  = object;
        ev.round   = round;
        return ev;
    endfunction

    // Present one request word and hold it until taken. Called at a falling edge;
    // returns at the falling edge after acceptance with s_tvalid still high, so
    // the caller either presents the next word or drops valid in that same step.
    task automatic issue_request(input logic req, input entry_t ev);
        int unsigned gap;
        gap = draw_pause();
        if (gap > 0)
        begin
            if (s_driving)
            begin
                s_tvalid  <= 1'b0;
                s_driving  = 1'b0;
            end
            repeat (gap) @(negedge clk);
        end
        s_tdata   <= {ev.round, ev.object, ev.subject, ev.kind, ev.key};
        s_tuser   <= req;
        s_tvalid  <= 1'b1;
        s_driving  = 1'b1;
        if (req == REQ_INSERT)
        begin
            if (fill_level < CAP)
                fill_level++;
        end
        else if (fill_level > 0)
        begin
            fill_level--;
        end
        do @(negedge clk); while (!s_took);
    endtask

    // Drop valid and hold the sender back until every due result has come out.
    task automatic hold_until_drained();
        if (s_driving)
        begin
            s_tvalid  <= 1'b0;
            s_driving  = 1'b0;
        end
        while (outstanding != 0) @(negedge clk);
    endtask

    // Random traffic: insert_pct percent inserts, the rest pops.
    task automatic mixed_traffic(input int unsigned words, input int unsigned insert_pct);
        entry_t ev;
        for (int unsigned i = 0; i < words; i++)
        begin
            ev = random_event();
            if ($urandom_range(0, 99) < insert_pct)
                issue_request(REQ_INSERT, ev);
            else
                issue_request(REQ_POP, ev);
        end
    endtask

    // Result side: stall before each word for a random pause, none during steady stretches.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            int unsigned stall;
            stall = draw_pause();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(negedge clk); while (!m_took);
        end
    end

    initial
    begin
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        s_driving  = 1'b0;
        steady     = 1'b0;
        fill_level = 0;
        rst_n      = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: pop on an empty heap, then extreme keys and payloads.
        issue_request(REQ_POP, make_event(32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        issue_request(REQ_INSERT, make_event(32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                                             16'hFFFF));
        issue_request(REQ_INSERT, make_event(32'd0, 8'h00, 16'h0000, 16'h0000, 16'h0000));
        // Three equal times: the order they come back in shows the tie rule.
        issue_request(REQ_INSERT, make_event(32'd7, 8'hA1, 16'h1111, 16'h2222, 16'h3333));
        issue_request(REQ_INSERT, make_event(32'd7, 8'hA2, 16'h4444, 16'h5555, 16'h6666));
        issue_request(REQ_INSERT, make_event(32'd7, 8'hA3, 16'h7777, 16'h8888, 16'h9999));
        issue_request(REQ_INSERT, make_event(32'hFFFF_FFFF, 8'h5A, 16'hA5A5, 16'h5A5A,
                                             16'hC3C3));
        issue_request(REQ_INSERT, make_event(32'd1, 8'h3C, 16'h0F0F, 16'hF0F0, 16'h00FF));
        // Drain all seven, then pop twice more on the empty heap.
        for (int i = 0; i < 9; i++)
            issue_request(REQ_POP, random_event());
        hold_until_drained();

        // Random traffic leaning towards inserts, so the heap grows deep.
        mixed_traffic(500, 60);
        hold_until_drained();

        // Fill to capacity, the first stretch with no idling on either side.
        steady = 1'b1;
        for (int i = 0; i < 300 && fill_level < CAP; i++)
            issue_request(REQ_INSERT, random_event());
        steady = 1'b0;
        while (fill_level < CAP)
            issue_request(REQ_INSERT, random_event());
        // Inserts into the full heap must be dropped and flagged.
        for (int i = 0; i < 6; i++)
            issue_request(REQ_INSERT, random_event());
        hold_until_drained();

        // Churn around the full mark, then lean towards pops.
        mixed_traffic(150, 50);
        mixed_traffic(150, 25);

        // Drop valid, wait for every result, then allow the longest pop to surface
        // anything spurious.
        hold_until_drained();
        repeat (40) @(negedge clk);

        if (fail_count == 0)
            $display("PASS event_min_heap_queue_top");
        else
            $display("FAIL event_min_heap_queue_top");
        $finish;
    end

    // Bound the run well beyond the slowest correct one.
    initial
    begin
        #2000000;
        $display("FAIL event_min_heap_queue_top");
        $finish;
    end

endmodule

// File: event_min_heap_queue_top.f
rtl/core/ehq_pkg.sv
rtl/core/ehq_mem.sv
rtl/core/ehq_ctrl.sv
rtl/core/event_min_heap_queue_top.sv
tb/heap_result_checker.sv
tb/tb_event_min_heap_queue_top.sv
